/* rtl/its_pkg.sv */
// ----------------------------------------------------------------------------
// its_pkg: shared types and constants of the inertial touch scroll block
// Event and action codes, limits, register indexes, and the structs passed
// between the configuration registers, the serial divider and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package its_pkg;

  localparam int MAX_SCROLL_CAP = 28671;
  localparam int VEL_WINDOW_MS  = 100;
  localparam int MS_PER_S       = 1000;
  localparam int VEL_CLAMP      = 4200;
  localparam int MIN_DURATION   = 220;
  localparam int SETTLE_VEL     = 80;
  localparam int SETTLE_DIST    = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int DIV_W  = 25;
  localparam int DSOR_W = 10;
  localparam int CNT_W  = 5;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_SCROLL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OVERSCROLL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOMENTUM     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INERTIA  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNCE       = 3'd5;

  localparam logic [14:0] RST_MAX_SCROLL  = 15'd0;
  localparam logic [11:0] RST_VIEWPORT    = 12'd320;
  localparam logic [11:0] RST_OVERSCROLL  = 12'd32;
  localparam logic [11:0] RST_MOMENTUM    = 12'd600;
  localparam logic [15:0] RST_MAX_INERTIA = 16'd1200;
  localparam logic [15:0] RST_BOUNCE      = 16'd200;

  typedef enum logic [1:0] {
    CMD_DOWN    = 2'd0,
    CMD_MOVE    = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_CANCEL  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_DRAG   = 2'd1,
    ACT_SETTLE = 2'd2,
    ACT_ANIM   = 2'd3
  } action_t;

  // effective register values, already saturated, floored or doubled
  typedef struct packed {
    logic [14:0] mx;
    logic [11:0] lim;
    logic [12:0] span;
    logic [11:0] mom;
    logic [15:0] hi;
    logic [15:0] bdur;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DSOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/its_if.sv */
// ----------------------------------------------------------------------------
// its_if: request channels of the inertial touch scroll block
// Touch event channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface its_touch_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [11:0] touch_y;
  logic [31:0] now_ms;
  logic signed [15:0] delta_y;
  logic [14:0] current_scroll;

  modport source (output valid, cmd, touch_y, now_ms, delta_y, current_scroll,
                  input ready);
  modport sink (input valid, cmd, touch_y, now_ms, delta_y, current_scroll,
                output ready);
endinterface

interface its_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic signed [15:0] position;
  logic signed [15:0] anim_target;
  logic [14:0] anim_final;
  logic [15:0] anim_duration;
  logic        second_leg;

  modport source (output valid, action, position, anim_target, anim_final,
                  anim_duration, second_leg, input ready);
  modport sink (input valid, action, position, anim_target, anim_final,
                anim_duration, second_leg, output ready);
endinterface

`default_nettype wire

/* rtl/its_cfg.sv */
// ----------------------------------------------------------------------------
// its_cfg: configuration registers
// Six write-only registers and their effective values (saturated max scroll,
// floored limits, doubled viewport span).
// ----------------------------------------------------------------------------
`default_nettype none

module its_cfg (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_we,
  input  wire [its_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [its_pkg::CFG_DATA_W-1:0]       cfg_data,
  output its_pkg::cfg_t                       cfg
);

  logic [14:0] max_scroll;
  logic [11:0] viewport_height;
  logic [11:0] overscroll_limit;
  logic [11:0] momentum_ms;
  logic [15:0] max_inertia_ms;
  logic [15:0] bounce_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_scroll       <= its_pkg::RST_MAX_SCROLL;
      viewport_height  <= its_pkg::RST_VIEWPORT;
      overscroll_limit <= its_pkg::RST_OVERSCROLL;
      momentum_ms      <= its_pkg::RST_MOMENTUM;
      max_inertia_ms   <= its_pkg::RST_MAX_INERTIA;
      bounce_ms        <= its_pkg::RST_BOUNCE;
    end else if (cfg_we) begin
      case (cfg_index)
        its_pkg::REG_MAX_SCROLL:  max_scroll       <= cfg_data[14:0];
        its_pkg::REG_VIEWPORT:    viewport_height  <= cfg_data[11:0];
        its_pkg::REG_OVERSCROLL:  overscroll_limit <= cfg_data[11:0];
        its_pkg::REG_MOMENTUM:    momentum_ms      <= cfg_data[11:0];
        its_pkg::REG_MAX_INERTIA: max_inertia_ms   <= cfg_data;
        its_pkg::REG_BOUNCE:      bounce_ms        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.mx   = (max_scroll > 15'(its_pkg::MAX_SCROLL_CAP)) ?
               15'(its_pkg::MAX_SCROLL_CAP) : max_scroll;
    cfg.lim  = (overscroll_limit == 12'd0) ? 12'd1 : overscroll_limit;
    cfg.span = {viewport_height, 1'b0};
    cfg.mom  = momentum_ms;
    cfg.hi   = (max_inertia_ms > 16'(its_pkg::MIN_DURATION)) ?
               max_inertia_ms : 16'(its_pkg::MIN_DURATION);
    cfg.bdur = (bounce_ms == 16'd0) ? 16'd1 : bounce_ms;
  end

endmodule

`default_nettype wire

/* rtl/its_div.sv */
// ----------------------------------------------------------------------------
// its_div: shared serial divider
// Restoring unsigned divide, one quotient bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
`default_nettype none

module its_div (
  input  wire                 clk,
  input  wire                 rst,
  input  its_pkg::div_req_t   req,
  output its_pkg::div_rsp_t   rsp
);

  localparam int DW = its_pkg::DIV_W;
  localparam int SW = its_pkg::DSOR_W;
  localparam int CW = its_pkg::CNT_W;

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [SW-1:0] rem;
  logic [DW-1:0] quo;
  logic [SW-1:0] dsor;
  logic [SW:0]   shifted;
  logic [SW:0]   trial;
  logic          ge;

  assign shifted = {rem, quo[DW-1]};
  assign trial   = shifted - {1'b0, dsor};
  assign ge      = (shifted >= {1'b0, dsor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.start && (cnt == CW'(DW - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      quo  <= req.dividend;
      dsor <= req.divisor;
    end else if (busy) begin
      rem <= ge ? trial[SW-1:0] : shifted[SW-1:0];
      quo <= {quo[DW-2:0], ge};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

/* rtl/inertial_touch_scroll.sv */
// Down, cancel and idle events run no divide; a release runs one divide and then sequencing;
// a move runs divides for instant velocity and smoothing when inside the velocity window,
// and for the rubber band when out of range. A result also waits for the previous one to
// leave the output.
// One event at a time; the next request is taken the cycle after the result is registered.
// Reset: synchronous, active high; clears drag state and loads register defaults.
// ----------------------------------------------------------------------------
// inertial_touch_scroll: touch drag, momentum and overscroll bounce
// Sequencer over one shared serial divider; drag state and result staging.
// ----------------------------------------------------------------------------
`default_nettype none

module inertial_touch_scroll (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_we,
  input  wire [its_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [its_pkg::CFG_DATA_W-1:0]  cfg_data,
  its_touch_if.sink                      touch,
  its_result_if.source                   result
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_START = 8'b0000_0010,
    S_LOAD  = 8'b0000_0100,
    S_WAIT  = 8'b0000_1000,
    S_BAND  = 8'b0001_0000,
    S_REL1  = 8'b0010_0000,
    S_REL2  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  typedef enum logic [1:0] {
    PH_INST   = 2'd0,
    PH_SMOOTH = 2'd1,
    PH_BAND   = 2'd2,
    PH_TR     = 2'd3
  } phase_t;

  its_pkg::cfg_t     cfg;
  its_pkg::div_req_t div_req;
  its_pkg::div_rsp_t div_rsp;

  state_t state;
  phase_t phase;

  // request latch
  its_pkg::cmd_t      cmd_r;
  logic [11:0]        ty_r;
  logic [31:0]        now_r;
  logic signed [15:0] dy_r;
  logic [14:0]        cur_r;

  // drag state
  logic               dragging;
  logic [11:0]        last_pos;
  logic [31:0]        last_time;
  logic signed [23:0] vel;
  logic [14:0]        start_off;
  logic signed [16:0] vis;

  // working registers
  logic signed [25:0] acc;
  logic [9:0]         dsor;
  logic               band_neg;
  logic signed [13:0] travel_r;
  logic [14:0]        fin_r;
  logic signed [17:0] tgt_r;
  logic               bounce_r;

  // result staging
  its_pkg::action_t   res_action;
  logic signed [15:0] res_pos;
  logic signed [15:0] res_tgt;
  logic [14:0]        res_fin;
  logic [15:0]        res_dur;
  logic               res_leg;

  its_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  its_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  logic signed [17:0] mx_s;
  logic signed [17:0] lim_s;
  logic signed [17:0] vis18;
  logic [31:0]        el;
  logic               win;
  logic signed [12:0] diff13;
  logic signed [25:0] numer;
  logic signed [13:0] velc;
  logic signed [25:0] mom26;
  logic signed [25:0] prod;
  logic               vel_small;
  logic signed [25:0] qs;
  logic signed [25:0] smooth_num;
  logic signed [17:0] s18;
  logic               s_lo;
  logic               s_hi;
  logic signed [17:0] band_num;
  logic [11:0]        dd;
  logic signed [17:0] band_pos;
  logic signed [25:0] span26;
  logic signed [13:0] travel;
  logic signed [17:0] raw;
  logic [14:0]        fin;
  logic               bounce;
  logic signed [17:0] tgt;
  logic signed [17:0] dlt;
  logic [17:0]        dist_px;
  logic [17:0]        dur18;
  logic [15:0]        dur;
  logic               settle;
  logic               leg;
  logic [14:0]        ctgt;
  logic [14:0]        start_c;

  assign mx_s  = $signed({3'b0, cfg.mx});
  assign lim_s = $signed({6'b0, cfg.lim});
  assign vis18 = 18'(vis);

  // move: instant velocity numerator
  assign el     = now_r - last_time;
  assign win    = (el != 32'd0) && (el <= 32'(its_pkg::VEL_WINDOW_MS));
  assign diff13 = $signed({1'b0, last_pos}) - $signed({1'b0, ty_r});
  assign numer  = 26'(diff13) * 26'(its_pkg::MS_PER_S);

  // release: clamped velocity times momentum time
  assign velc = (vel > 24'(its_pkg::VEL_CLAMP)) ? 14'(its_pkg::VEL_CLAMP) :
                (vel < -24'(its_pkg::VEL_CLAMP)) ? -14'(its_pkg::VEL_CLAMP) :
                14'(vel);
  assign mom26     = $signed({14'b0, cfg.mom});
  assign prod      = 26'(velc) * mom26;
  assign vel_small = (vel < 24'(its_pkg::SETTLE_VEL)) &&
                     (vel > -24'(its_pkg::SETTLE_VEL));

  // signed quotient, truncated toward zero
  assign qs = acc[25] ? -$signed({1'b0, div_rsp.quotient}) :
                        $signed({1'b0, div_rsp.quotient});
  assign smooth_num = (26'(vel) <<< 1) + qs;

  // rubber band
  assign s18      = $signed({3'b0, start_off}) - 18'(dy_r);
  assign s_lo     = (s18 < 18'sd0);
  assign s_hi     = (s18 > mx_s);
  assign band_num = s_lo ? (18'sd2 - s18) : (s18 - mx_s + 18'sd2);
  assign dd       = (div_rsp.quotient < 25'(cfg.lim)) ? div_rsp.quotient[11:0] : cfg.lim;
  assign band_pos = band_neg ? -$signed({6'b0, dd}) : mx_s + $signed({6'b0, dd});

  // release travel and targets
  assign span26 = $signed({13'b0, cfg.span});
  assign travel = (qs > span26) ? $signed({1'b0, cfg.span}) :
                  (qs < -span26) ? -$signed({1'b0, cfg.span}) : 14'(qs);
  assign raw    = vis18 + 18'(travel_r);
  assign fin    = (raw < 18'sd0) ? 15'd0 : (raw > mx_s) ? cfg.mx : raw[14:0];
  assign bounce = (vis18 < 18'sd0) || (vis18 > mx_s) || (raw < 18'sd0) || (raw > mx_s);
  assign tgt    = !bounce ? $signed({3'b0, fin}) :
                  (raw < -lim_s) ? -lim_s :
                  (raw > mx_s + lim_s) ? mx_s + lim_s : raw;

  assign dlt     = tgt_r - vis18;
  assign dist_px = dlt[17] ? 18'(-dlt) : 18'(dlt);
  assign dur18   = 18'(its_pkg::MIN_DURATION) + (dist_px >> 1);
  assign dur     = (dur18 > {2'b0, cfg.hi}) ? cfg.hi : dur18[15:0];
  assign settle  = !bounce_r && (dist_px < 18'(its_pkg::SETTLE_DIST)) && vel_small;
  assign leg     = bounce_r && (tgt_r != $signed({3'b0, fin_r}));

  assign ctgt    = (vis18 < 18'sd0) ? 15'd0 : (vis18 > mx_s) ? cfg.mx : vis[14:0];
  assign start_c = (cur_r > cfg.mx) ? cfg.mx : cur_r;

  assign div_req.start    = (state == S_LOAD);
  assign div_req.dividend = acc[25] ? 25'(-acc) : acc[24:0];
  assign div_req.divisor  = dsor;

  assign touch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      dragging     <= 1'b0;
      last_pos     <= '0;
      last_time    <= '0;
      vel          <= '0;
      start_off    <= '0;
      vis          <= '0;
      result.valid <= 1'b0;
    end else begin
      if (result.ready && (state != S_DONE)) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (touch.valid) begin
            cmd_r      <= its_pkg::cmd_t'(touch.cmd);
            ty_r       <= touch.touch_y;
            now_r      <= touch.now_ms;
            dy_r       <= touch.delta_y;
            cur_r      <= touch.current_scroll;
            res_action <= its_pkg::ACT_NONE;
            res_pos    <= '0;
            res_tgt    <= '0;
            res_fin    <= '0;
            res_dur    <= '0;
            res_leg    <= 1'b0;
            state      <= S_START;
          end
        end
        S_START: begin
          if (cmd_r == its_pkg::CMD_DOWN) begin
            last_pos  <= ty_r;
            last_time <= now_r;
            vel       <= '0;
            start_off <= start_c;
            vis       <= 17'(start_c);
            dragging  <= 1'b1;
            state     <= S_DONE;
          end else if (dragging) begin
            case (cmd_r)
              its_pkg::CMD_MOVE: begin
                acc       <= numer;
                dsor      <= el[9:0];
                phase     <= PH_INST;
                last_pos  <= ty_r;
                last_time <= now_r;
                state     <= win ? S_LOAD : S_BAND;
              end
              its_pkg::CMD_RELEASE: begin
                acc   <= prod;
                dsor  <= 10'(its_pkg::MS_PER_S);
                phase <= PH_TR;
                state <= S_LOAD;
              end
              default: begin
                vel        <= '0;
                res_action <= its_pkg::ACT_ANIM;
                res_tgt    <= 16'(ctgt);
                res_fin    <= ctgt;
                res_dur    <= cfg.bdur;
                vis        <= 17'(ctgt);
                dragging   <= 1'b0;
                state      <= S_DONE;
              end
            endcase
          end else begin
            state <= S_DONE;
          end
        end
        S_LOAD: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_rsp.done) begin
            case (phase)
              PH_INST: begin
                acc   <= smooth_num;
                dsor  <= 10'd3;
                phase <= PH_SMOOTH;
                state <= S_LOAD;
              end
              PH_SMOOTH: begin
                vel   <= 24'(qs);
                state <= S_BAND;
              end
              PH_BAND: begin
                vis        <= 17'(band_pos);
                res_action <= its_pkg::ACT_DRAG;
                res_pos    <= 16'(band_pos);
                state      <= S_DONE;
              end
              default: begin
                travel_r <= travel;
                state    <= S_REL1;
              end
            endcase
          end
        end
        S_BAND: begin
          if (s_lo || s_hi) begin
            acc      <= 26'(band_num);
            dsor     <= 10'd3;
            band_neg <= s_lo;
            phase    <= PH_BAND;
            state    <= S_LOAD;
          end else begin
            vis        <= 17'(s18);
            res_action <= its_pkg::ACT_DRAG;
            res_pos    <= 16'(s18);
            state      <= S_DONE;
          end
        end
        S_REL1: begin
          fin_r    <= fin;
          tgt_r    <= tgt;
          bounce_r <= bounce;
          state    <= S_REL2;
        end
        S_REL2: begin
          vis      <= 17'(fin_r);
          dragging <= 1'b0;
          if (settle) begin
            res_action <= its_pkg::ACT_SETTLE;
            res_pos    <= 16'(fin_r);
          end else begin
            res_action <= its_pkg::ACT_ANIM;
            res_tgt    <= 16'(tgt_r);
            res_fin    <= fin_r;
            res_dur    <= dur;
            res_leg    <= leg;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!result.valid || result.ready) begin
            result.valid         <= 1'b1;
            result.action        <= res_action;
            result.position      <= res_pos;
            result.anim_target   <= res_tgt;
            result.anim_final    <= res_fin;
            result.anim_duration <= res_dur;
            result.second_leg    <= res_leg;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_busy_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.busy |-> (state == S_WAIT))
    else $error("divider running outside wait state");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (touch.valid && touch.ready) |=> (state == S_START))
    else $error("accepted request did not start");

  a_anim_ends_drag: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && (res_action == its_pkg::ACT_ANIM)) |-> !dragging)
    else $error("animation result while still dragging");

  a_drag_keeps_drag: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && (res_action == its_pkg::ACT_DRAG)) |-> dragging)
    else $error("drag result without an active drag");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && result.valid && !result.ready) |=> (state == S_DONE))
    else $error("result staging overwrote a pending result");
`endif

endmodule

`default_nettype wire
